// ===== rtl/core/mpq_pkg.sv =====
// Shared types and constants for the min priority queue.
package mpq_pkg;

	localparam int KEY_W        = 32;
	localparam int COUNT_OUT_W  = 9;
	localparam int DEF_CAPACITY = 256;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic signed [KEY_W-1:0] KEY_FLOOR = {1'b1, {(KEY_W-1){1'b0}}};

	typedef struct packed {
		logic                    vld;
		logic signed [KEY_W-1:0] key;
	} mpq_ent_t;

	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [KEY_W-1:0] key;
	} mpq_cmd_t;

endpackage

// ===== rtl/core/min_priority_queue.sv =====
// Min priority queue top level: cell chain, entry count and result register.
//
// Keys live in a chain of CAPACITY cells kept in ascending order; an insert
// or a removal updates every cell in the single cycle in which the request
// transaction is accepted, and the result (minimum, count, empty, rejected)
// is loaded into the output register as soon as that register is free, so
// in_ready stays low from acceptance until the result load. One finished
// result may wait on out_ready while the next request is taken; a second
// one then holds in_ready low until the output register frees. Removal
// from an empty queue leaves it unchanged; an insert into a full queue is
// dropped and flagged.
module min_priority_queue
	import mpq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic signed [KEY_W-1:0]       key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [KEY_W-1:0]       min_key,
	output logic                          is_empty,
	output logic                          rejected,
	output logic        [COUNT_OUT_W-1:0] entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	mpq_ent_t               ent [CAPACITY];
	mpq_cmd_t               cmd;
	logic                   accept;
	logic                   full;
	logic [CNT_W-1:0]       count_q;
	logic                   pend_q;
	logic                   rej_q;
	logic                   out_valid_q;
	logic signed [KEY_W-1:0] min_key_q;
	logic                   is_empty_q;
	logic                   rejected_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;
	logic                   load;

	assign in_ready = !pend_q;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CAP_CNT);
	assign load     = pend_q && (!out_valid_q || out_ready);

	assign cmd.ins = accept && (req_type == REQ_INSERT) && !full;
	assign cmd.rem = accept && (req_type == REQ_REMOVE) && (count_q != '0);
	assign cmd.key = key;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mpq_ent_t left_ent;
		mpq_ent_t right_ent;

		if (i == 0) begin : g_first
			assign left_ent = '{vld: 1'b1, key: KEY_FLOOR};
		end else begin : g_mid_l
			assign left_ent = ent[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_ent = '{vld: 1'b0, key: '0};
		end else begin : g_mid_r
			assign right_ent = ent[i+1];
		end

		mpq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (left_ent),
			.right  (right_ent),
			.ent    (ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.rem) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				pend_q <= 1'b1;
				rej_q  <= (req_type == REQ_INSERT) && full;
			end else if (load) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			min_key_q     <= (count_q != '0) ? ent[0].key : '0;
			is_empty_q    <= (count_q == '0);
			rejected_q    <= rej_q;
			entry_count_q <= COUNT_OUT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign min_key     = min_key_q;
	assign is_empty    = is_empty_q;
	assign rejected    = rejected_q;
	assign entry_count = entry_count_q;

	a_head_vld: assert property (@(posedge clk) disable iff (!arst_n)
		ent[0].vld == (count_q != '0))
		else $error("head cell valid disagrees with entry count");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_rej_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && rej_q |-> full)
		else $error("reject flagged while queue not full");

	a_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_q && !in_ready)
		else $error("accepted transaction not held pending");

endmodule

// ===== rtl/core/mpq_cell.sv =====
// One cell of the sorted key chain: holds one key, trades with its neighbors.
module mpq_cell
	import mpq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mpq_cmd_t cmd,
	input  mpq_ent_t left,
	input  mpq_ent_t right,
	output mpq_ent_t ent
);

	logic                    vld_q;
	logic signed [KEY_W-1:0] key_q;
	logic                    shift_in;
	logic                    take;

	// insert: move right if the key sorts before the left neighbor,
	// land here if it sorts between the left neighbor and this cell
	assign shift_in = cmd.ins && left.vld && (cmd.key < left.key);
	assign take     = cmd.ins && left.vld && !(cmd.key < left.key)
	                  && (!vld_q || (cmd.key < key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift_in) begin
			vld_q <= left.vld;
		end else if (take) begin
			vld_q <= 1'b1;
		end else if (cmd.rem) begin
			vld_q <= right.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_in) begin
			key_q <= left.key;
		end else if (take) begin
			key_q <= cmd.key;
		end else if (cmd.rem) begin
			key_q <= right.key;
		end
	end

	assign ent.vld = vld_q;
	assign ent.key = key_q;

endmodule

// ===== tb/sv/min_priority_queue_test.sv =====
// Self-checking testbench for min_priority_queue: random and directed requests, scoreboard check.
module min_priority_queue_test;
	import mpq_pkg::*;

	localparam int CAPACITY    = DEF_CAPACITY;
	localparam int REQUESTS    = 1850;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct {
		key_t                   min_key;
		logic                   is_empty;
		logic                   rejected;
		logic [COUNT_OUT_W-1:0] entry_count;
	} queue_status_t;

	class queue_scoreboard;
		key_t          sorted_keys[$];
		queue_status_t awaited[$];
		int            errors = 0;

		function void note_request(logic rt, key_t k);
			queue_status_t s;
			int pos;
			s.rejected = 1'b0;
			if (rt == REQ_INSERT) begin
				if (sorted_keys.size() >= CAPACITY) begin
					s.rejected = 1'b1;
				end else begin
					pos = 0;
					while (pos < sorted_keys.size() && sorted_keys[pos] <= k)
						pos++;
					sorted_keys.insert(pos, k);
				end
			end else if (sorted_keys.size() > 0) begin
				void'(sorted_keys.pop_front());
			end
			s.is_empty    = (sorted_keys.size() == 0);
			s.min_key     = s.is_empty ? key_t'(0) : sorted_keys[0];
			s.entry_count = COUNT_OUT_W'(sorted_keys.size());
			awaited.push_back(s);
		endfunction

		function void check_result(key_t mk, logic emp, logic rej,
				logic [COUNT_OUT_W-1:0] cnt);
			queue_status_t s;
			if (awaited.size() == 0) begin
				$error("unexpected result transaction: min_key %0d entry_count %0d", mk, cnt);
				errors++;
				return;
			end
			s = awaited.pop_front();
			if (mk !== s.min_key) begin
				$error("min_key expected %0d actual %0d", s.min_key, mk);
				errors++;
			end
			if (emp !== s.is_empty) begin
				$error("is_empty expected %0b actual %0b", s.is_empty, emp);
				errors++;
			end
			if (rej !== s.rejected) begin
				$error("rejected expected %0b actual %0b", s.rejected, rej);
				errors++;
			end
			if (cnt !== s.entry_count) begin
				$error("entry_count expected %0d actual %0d", s.entry_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   req_type = REQ_INSERT;
	key_t                   key = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	key_t                   min_key;
	logic                   is_empty;
	logic                   rejected;
	logic [COUNT_OUT_W-1:0] entry_count;

	queue_scoreboard sb = new();
	logic            steady = 1'b0;
	int              sent = 0;
	int              cycles = 0;

	min_priority_queue #(.CAPACITY(CAPACITY)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.min_key    (min_key),
		.is_empty   (is_empty),
		.rejected   (rejected),
		.entry_count(entry_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 19);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(min_key, is_empty, rejected, entry_count);
	end

	function automatic key_t random_key();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return KEY_FLOOR;
					1: return ~KEY_FLOOR;
					2: return key_t'(0);
					default: return key_t'(-1);
				endcase
			end
			1, 2, 3: return key_t'($urandom_range(0, 15)) - key_t'(8);
			default: return key_t'($urandom);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic rt, input key_t k);
		while (!steady && $urandom_range(0, 99) < 19) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = rt;
		key      = k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(rt, k);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty removal, key extremes, duplicate minimum
		send_request(REQ_REMOVE, key_t'(0));
		send_request(REQ_INSERT, ~KEY_FLOOR);
		send_request(REQ_INSERT, KEY_FLOOR);
		send_request(REQ_INSERT, key_t'(0));
		send_request(REQ_INSERT, key_t'(-1));
		send_request(REQ_INSERT, KEY_FLOOR);
		send_request(REQ_INSERT, key_t'(1));
		send_request(REQ_REMOVE, key_t'(-1));
		send_request(REQ_REMOVE, key_t'(0));
		repeat (3) send_request(REQ_INSERT, key_t'(7));
		repeat (3) send_request(REQ_REMOVE, ~KEY_FLOOR);
		repeat (6) send_request(REQ_REMOVE, random_key());

		repeat (500)
			send_request(($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_REMOVE,
				random_key());

		wait_for_results();

		// fill to capacity, then inserts that must be rejected
		steady = 1'b1;
		while (sb.sorted_keys.size() < CAPACITY)
			send_request(($urandom_range(0, 9) == 0) ? REQ_REMOVE : REQ_INSERT,
				random_key());
		repeat (12) send_request(REQ_INSERT, random_key());
		send_request(REQ_REMOVE, random_key());
		send_request(REQ_INSERT, random_key());
		send_request(REQ_INSERT, random_key());
		steady = 1'b0;

		while (sb.sorted_keys.size() > 0)
			send_request(($urandom_range(0, 99) < 15) ? REQ_INSERT : REQ_REMOVE,
				random_key());
		repeat (4) send_request(REQ_REMOVE, random_key());

		while (sent < REQUESTS)
			send_request(($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_REMOVE,
				random_key());

		wait_for_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
